### rtl/core/sic_pkg.sv
// Shared constants and types for the separable image convolution block.
`default_nettype none
package sic_pkg;
  localparam int unsigned MaxWidthDef  = 512;
  localparam int unsigned MaxHeightDef = 512;
  localparam int unsigned MaxRadiusDef = 7;
  localparam int unsigned PixelBitsDef = 16;
  localparam int unsigned CoefBitsDef  = 16;
  localparam int unsigned NumTaps      = 15;
  localparam int unsigned WinDepth     = 15;
  localparam int unsigned LineCount    = 14;

  localparam logic [2:0] RegRadius = 3'd0;
  localparam logic [2:0] RegWidth  = 3'd1;
  localparam logic [2:0] RegHeight = 3'd2;
  localparam logic [2:0] RegCoef0  = 3'd3;
  localparam logic [2:0] RegCoef3  = 3'd6;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ROWP  = 7'b0000010,
    ST_ROWW  = 7'b0000100,
    ST_COLP  = 7'b0001000,
    ST_COLW  = 7'b0010000,
    ST_EMIT  = 7'b0100000,
    ST_NEXT  = 7'b1000000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic       load_pix;   // store pixel into row window
    logic       row_clr;    // start row accumulation
    logic       row_tap;    // accumulate one row tap
    logic       row_fin;    // round row result into rowres
    logic       col_clr;
    logic       col_rd;     // issue line read for a column tap
    logic       col_tap;    // accumulate one column tap
    logic       col_fin;    // round column result to output
    logic       line_wr;    // write rowres[i] to line store
    logic [3:0] tap;        // k + R
    logic [2:0] idx;        // i within run
  } cmd_t;

  typedef struct packed {
    logic [15:0] acc_dummy;
  } stat_t;
endpackage
`default_nettype wire

### rtl/core/sic_if.sv
// Valid/ready stream and configuration interfaces.
`default_nettype none
interface sic_stream_if #(parameter int unsigned W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sic_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/sic_ram.sv
// Generic single-port-write, one-read RAM with registered read.
`default_nettype none
module sic_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/core/sic_datapath.sv
// Datapath: row window, line store, shared multiply-accumulate and rounding.
`default_nettype none
module sic_datapath import sic_pkg::*; #(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned PixelBits = PixelBitsDef,
  parameter int unsigned CoefBits  = CoefBitsDef
) (
  input  wire logic                    clk_i,
  input  wire cmd_t                    cmd_i,
  input  wire logic [PixelBits-1:0]    pixel_i,
  input  wire logic [3:0]              win_wr_i,    // row-window write slot
  input  wire logic [3:0]              win_rd_i,    // row-window tap slot
  input  wire logic [$clog2(MaxWidth)-1:0] x_i,     // output column
  input  wire logic [3:0]              line_rd_i,   // line slot to read
  input  wire logic [3:0]              line_wr_i,   // line slot to write
  input  wire logic                    use_cur_i,   // column tap is current row
  input  wire logic [4*64-1:0]         coef_i,
  output logic [PixelBits-1:0]         value_o
);
  localparam int unsigned XW = $clog2(MaxWidth);
  localparam int unsigned LD = LineCount * MaxWidth;
  localparam int unsigned AW = $clog2(LD);
  localparam int unsigned AccW = PixelBits + CoefBits + 5;

  logic [PixelBits-1:0] win_q [WinDepth];
  logic [PixelBits-1:0] rowres_q [MaxRadiusDef+1];
  logic signed [AccW-1:0] acc_q, acc_d, acc_sum;
  logic [PixelBits-1:0] line_rd;
  logic signed [CoefBits-1:0] cf;
  logic [PixelBits-1:0] opnd;
  logic [PixelBits-1:0] rnd;
  logic signed [PixelBits+CoefBits:0] prod_q;
  logic prod_v_q;
  logic [XW+3:0] wa, ra;

  always_comb begin
    logic [63:0] word;
    word = coef_i[cmd_i.tap[3:2]*64 +: 64];
    cf = word[cmd_i.tap[1:0]*16 +: CoefBits];
  end

  assign wa = (XW+4)'(line_wr_i) * (XW+4)'(MaxWidth) + (XW+4)'(x_i);
  assign ra = (XW+4)'(line_rd_i) * (XW+4)'(MaxWidth) + (XW+4)'(x_i);

  sic_ram #(.Width(PixelBits), .Depth(LD)) u_lines (
    .clk_i, .we_i(cmd_i.line_wr), .waddr_i(AW'(wa)),
    .wdata_i(rowres_q[cmd_i.idx]), .raddr_i(AW'(ra)), .rdata_o(line_rd)
  );

  always_comb begin
    if (cmd_i.row_tap) opnd = win_q[win_rd_i];
    else if (use_cur_i) opnd = rowres_q[cmd_i.idx];
    else opnd = line_rd;
  end

  always_comb begin
    acc_sum = prod_v_q ? acc_q + AccW'(prod_q) : acc_q;
    acc_d = (cmd_i.row_clr || cmd_i.col_clr) ? '0 : acc_sum;
  end

  always_comb begin
    logic signed [AccW-1:0] t;
    t = acc_sum + (AccW'(1) <<< (CoefBits-2));
    if (t < 0) rnd = '0;
    else if ((t >>> (CoefBits-1)) > AccW'((1 << PixelBits) - 1)) rnd = '1;
    else rnd = PixelBits'(t >>> (CoefBits-1));
  end

  always_ff @(posedge clk_i) begin
    prod_v_q <= cmd_i.row_tap || cmd_i.col_tap;
    prod_q   <= $signed({1'b0, opnd}) * cf;
    acc_q    <= acc_d;
    if (cmd_i.load_pix) win_q[win_wr_i] <= pixel_i;
    if (cmd_i.row_fin) rowres_q[cmd_i.idx] <= rnd;
    if (cmd_i.col_fin) value_o <= rnd;
  end
endmodule
`default_nettype wire

### rtl/core/sic_ctrl.sv
// Controller: counters, run sequencing and output handshake.
`default_nettype none
module sic_ctrl import sic_pkg::*; #(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned MaxHeight = MaxHeightDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire logic restart_i,
  input  wire logic [2:0] radius_i,
  input  wire logic [9:0] width_i,
  input  wire logic [9:0] height_i,
  output cmd_t      cmd_o,
  output logic [3:0] win_wr_o,
  output logic [3:0] win_rd_o,
  output logic [$clog2(MaxWidth)-1:0] x_o,
  output logic [$clog2(MaxHeight)-1:0] y_o,
  output logic [3:0] line_rd_o,
  output logic [3:0] line_wr_o,
  output logic use_cur_o,
  output logic last_o,
  output logic done_o
);
  localparam int unsigned XW = $clog2(MaxWidth);
  localparam int unsigned YW = $clog2(MaxHeight);
  state_e st_q, st_d;
  logic [XW-1:0] c_q, c_d;
  logic [YW-1:0] r_q, r_d;
  logic [3:0] cm_q, cm_d, rm_q, rm_d;
  logic [3:0] tap_q, tap_d;
  logic [2:0] i_q, i_d;
  logic [YW-1:0] y_q, y_d;
  logic [XW-1:0] w1, x0, nxm1, rx;
  logic [YW-1:0] h1, y0, ylast, dy;
  logic [3:0] dxw, dyw;
  logic [2:0] rad;
  logic has_out, hasrow, lastc, lastr, fin_q, fin_d;

  always_comb begin
    logic [10:0] w, h;
    w = (width_i == 0) ? 11'd1 : (11'(width_i) > 11'(MaxWidth) ? 11'(MaxWidth) : 11'(width_i));
    h = (height_i == 0) ? 11'd1 : (11'(height_i) > 11'(MaxHeight) ? 11'(MaxHeight) : 11'(height_i));
    w1 = XW'(w - 11'd1);
    h1 = YW'(h - 11'd1);
    rad = (radius_i > 3'(MaxRadiusDef)) ? 3'(MaxRadiusDef) : radius_i;
  end

  assign lastc = (c_q == w1);
  assign lastr = (r_q == h1);
  always_comb begin
    x0 = '0; nxm1 = '0; y0 = '0; ylast = r_q;
    if (lastc) begin
      x0 = (c_q >= XW'(rad)) ? c_q - XW'(rad) : '0;
      nxm1 = c_q - x0;
    end else x0 = c_q - XW'(rad);
    if (lastr) y0 = (r_q >= YW'(rad)) ? r_q - YW'(rad) : '0;
    else begin
      y0 = r_q - YW'(rad);
      ylast = y0;
    end
  end
  assign hasrow = lastc || c_q >= XW'(rad);
  assign has_out = hasrow && (lastr || r_q >= YW'(rad));

  assign x_o = x0 + XW'(i_q);
  assign y_o = y_q;
  assign win_wr_o = cm_q;
  always_comb begin
    logic signed [XW+1:0] t;
    t = $signed({2'b0, x_o}) + $signed((XW+2)'(tap_q)) - $signed((XW+2)'(rad));
    if (t < 0) rx = '0;
    else if (t > $signed({2'b0, w1})) rx = w1;
    else rx = XW'(t);
  end
  assign dxw = 4'(c_q - rx);
  assign win_rd_o = (cm_q >= dxw) ? cm_q - dxw : cm_q + 4'(WinDepth) - dxw;
  always_comb begin
    logic signed [YW+1:0] t;
    t = $signed({2'b0, y_q}) + $signed((YW+2)'(tap_q)) - $signed((YW+2)'(rad));
    if (t < 0) dy = '0;
    else if (t > $signed({2'b0, r_q})) dy = r_q;
    else dy = YW'(t);
  end
  assign dyw = 4'(r_q - dy);
  assign use_cur_o = (dy == r_q);
  assign line_rd_o = (rm_q >= dyw) ? rm_q - dyw : rm_q + 4'(LineCount) - dyw;
  assign line_wr_o = rm_q;
  assign last_o = fin_q;
  assign done_o = fin_q && lastc && lastr;
  assign in_ready_o = (st_q == ST_IDLE);
  assign out_valid_o = (st_q == ST_EMIT) && (tap_q == 4'hF);

  always_comb begin
    st_d = st_q; c_d = c_q; r_d = r_q; tap_d = tap_q; i_d = i_q; y_d = y_q;
    cm_d = cm_q; rm_d = rm_q;
    fin_d = fin_q;
    cmd_o = '0;
    cmd_o.tap = tap_q;
    cmd_o.idx = i_q;
    case (st_q)
      ST_IDLE: if (in_valid_i) begin
        cmd_o.load_pix = 1'b1;
        i_d = '0; tap_d = '0; cmd_o.row_clr = 1'b1;
        st_d = hasrow ? ST_ROWP : ST_NEXT;
      end
      ST_ROWP: begin
        cmd_o.row_tap = 1'b1;
        if (tap_q == {rad, 1'b0}) st_d = ST_ROWW;
        else tap_d = tap_q + 4'd1;
      end
      ST_ROWW: begin
        cmd_o.row_fin = 1'b1; cmd_o.row_clr = 1'b1; tap_d = '0;
        if (i_q == 3'(nxm1)) begin
          i_d = '0;
          if (has_out) begin
            y_d = y0; st_d = ST_COLP; cmd_o.col_rd = 1'b1;
          end else st_d = ST_NEXT;
        end else begin
          i_d = i_q + 3'd1; st_d = ST_ROWP;
        end
      end
      ST_COLP: begin
        cmd_o.col_rd = 1'b1;
        st_d = ST_COLW;
      end
      ST_COLW: begin
        cmd_o.col_tap = 1'b1;
        if (tap_q == {rad, 1'b0}) begin
          st_d = ST_EMIT; fin_d = 1'b0;
        end else begin
          tap_d = tap_q + 4'd1; st_d = ST_COLP;
        end
      end
      ST_EMIT: begin
        if (fin_q == 1'b0 && tap_q != 4'hF) begin
          cmd_o.col_fin = 1'b1; tap_d = 4'hF;
          fin_d = (i_q == 3'(nxm1)) && (y_q == ylast);
          st_d = ST_EMIT;
        end
        if (tap_q == 4'hF && out_ready_i) begin
          cmd_o.col_clr = 1'b1; tap_d = '0;
          if (fin_d) begin
            st_d = ST_NEXT; i_d = '0;
          end else begin
            st_d = ST_COLP;
            if (i_q == 3'(nxm1)) begin i_d = '0; y_d = y_q + YW'(1); end
            else i_d = i_q + 3'd1;
          end
          fin_d = 1'b0;
        end
      end
      ST_NEXT: begin
        cmd_o.line_wr = hasrow;
        if (i_q == 3'(nxm1) || !hasrow) begin
          i_d = '0; st_d = ST_IDLE;
          if (lastc) begin
            c_d = '0; cm_d = '0;
            r_d = lastr ? '0 : r_q + YW'(1);
            rm_d = (lastr || rm_q == 4'(LineCount - 1)) ? '0 : rm_q + 4'd1;
          end else begin
            c_d = c_q + XW'(1);
            cm_d = (cm_q == 4'(WinDepth - 1)) ? '0 : cm_q + 4'd1;
          end
        end else i_d = i_q + 3'd1;
      end
      default: st_d = ST_IDLE;
    endcase
    if (restart_i) begin
      c_d = '0; r_d = '0; cm_d = '0; rm_d = '0; st_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; c_q <= '0; r_q <= '0; tap_q <= '0; i_q <= '0;
      cm_q <= '0; rm_q <= '0;
      y_q <= '0; fin_q <= 1'b0;
    end else begin
      st_q <= st_d; c_q <= c_d; r_q <= r_d; tap_q <= tap_d; i_q <= i_d;
      cm_q <= cm_d; rm_q <= rm_d;
      y_q <= y_d; fin_q <= fin_d;
    end
  end
endmodule
`default_nettype wire

### rtl/core/separable_image_convolution_top.sv
// Top level of the separable image convolution block.
// Channels: in_if (pixel request), out_if (result request carrying value,
// column, row, last_in_run, frame_done), cfg_if (register index and data).
// Pixels arrive in raster order. One shared multiplier runs the row pass
// then the column pass for each accepted input, so the multiply-accumulate
// unit serves both passes. Results come out in raster order of the output
// image, the last of each run marked, the last of the frame flagged.
// Reset clears the counters and loads default registers; line store contents
// are undefined until written. A stalled receiver holds the result, and the
// block accepts no pixel until the run has drained.
// Writes to radius, width or height restart the frame.
`default_nettype none
module separable_image_convolution_top import sic_pkg::*; #(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned MaxHeight = MaxHeightDef,
  parameter int unsigned PixelBits = PixelBitsDef,
  parameter int unsigned CoefBits  = CoefBitsDef
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  sic_stream_if.sink   in_if,
  sic_stream_if.source out_if,
  sic_cfg_if.sink      cfg_if
);
  localparam int unsigned XW = $clog2(MaxWidth);
  localparam int unsigned YW = $clog2(MaxHeight);
  logic [2:0] rad_q;
  logic [9:0] wid_q, hgt_q;
  logic [4*64-1:0] coef_q;
  logic cfg_we, restart;
  cmd_t cmd;
  logic [3:0] win_wr, win_rd;
  logic [XW-1:0] x;
  logic [YW-1:0] y;
  logic [3:0] lrd, lwr;
  logic use_cur, last, done;
  logic [PixelBits-1:0] val;

  assign cfg_if.ready = 1'b1;
  assign cfg_we = cfg_if.valid;
  assign restart = cfg_we && (cfg_if.index <= RegHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q <= '0; wid_q <= 10'd512; hgt_q <= 10'd512;
      coef_q <= {192'b0, 64'd32767};
    end else if (cfg_we) begin
      case (cfg_if.index)
        RegRadius: rad_q <= cfg_if.data[2:0];
        RegWidth:  wid_q <= cfg_if.data[9:0];
        RegHeight: hgt_q <= cfg_if.data[9:0];
        default: if (cfg_if.index >= RegCoef0 && cfg_if.index <= RegCoef3)
          coef_q[(cfg_if.index - RegCoef0)*64 +: 64] <= cfg_if.data;
      endcase
    end
  end

  sic_ctrl #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .restart_i(restart),
    .radius_i(rad_q), .width_i(wid_q), .height_i(hgt_q), .cmd_o(cmd),
    .win_wr_o(win_wr), .win_rd_o(win_rd), .x_o(x), .y_o(y), .line_rd_o(lrd),
    .line_wr_o(lwr), .use_cur_o(use_cur), .last_o(last), .done_o(done)
  );

  sic_datapath #(.MaxWidth(MaxWidth), .PixelBits(PixelBits), .CoefBits(CoefBits)) u_dp (
    .clk_i, .cmd_i(cmd), .pixel_i(in_if.data[PixelBits-1:0]), .win_wr_i(win_wr),
    .win_rd_i(win_rd), .x_i(x), .line_rd_i(lrd), .line_wr_i(lwr), .use_cur_i(use_cur),
    .coef_i(coef_q), .value_o(val)
  );

  assign out_if.data = {16'(val), 9'(x), 9'(y), last, done};

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_if.ready && out_if.valid)) else $error("input and output active together");
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && done |-> last) else $error("frame_done without last_in_run");
endmodule
`default_nettype wire
